// File: src/ist_pkg.sv
// shared types, constants and codes for the integer set table
package ist_pkg;

  localparam int CAPACITY  = 16;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int RND_W     = 16;
  localparam int MOD_CNT_W = $clog2(RND_W + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_SAMPLE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PREP_DN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SAMPLE_RD,
    S_FIN_OK,
    S_FIN_DUP,
    S_FIN_FULL,
    S_FIN_ABSENT,
    S_FIN_EMPTY,
    S_FIN_INS,
    S_FIN_REM,
    S_FIN_SAMPLE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan;
    logic    dn_init;
    logic    shift_up;
    logic    shift_dn;
    logic    sample_rd;
    logic    finish;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    wr_head;
    logic    take_sample;
    status_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  scan_done;
    logic  mod_done;
    logic  shift_done;
    logic  found;
    logic  full;
    logic  empty;
    func_t func;
  } stat_t;

endpackage

// File: src/integer_set_table.sv
// top level of the integer set table: sequencer plus datapath
// A request word is taken when start is high and busy is low. Busy then stays high
// until the request is finished. The result word appears in the cycle after the
// finish state, with out_valid high for exactly one cycle, and the receiver cannot
// stall. Each request first scans the stored entries through the single read port
// of the element memory, one entry per cycle, with the compare pipelined behind
// the read. At the same time a bit-serial remainder unit works through the 16-bit
// random word. The scan phase ends when both the scan and the remainder are done.
// After the scan:
// - an insert moves every entry up one place
// - a remove passes through a setup state and then moves the entries above the
//   match down
// - a sample reads the entry at the remainder index
// A finish state then follows. A new request can be accepted at the edge that ends
// the result cycle. No clearing pass runs after reset.
module integer_set_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic signed [ist_pkg::VAL_W-1:0]   in_value,
  input  logic [ist_pkg::RND_W-1:0]          in_random_word,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic                               out_is_member,
  output logic signed [ist_pkg::VAL_W-1:0]   out_sample_value,
  output logic [ist_pkg::CNT_W-1:0]          out_element_count,
  output logic                               out_set_empty
);

  ist_pkg::cmd_t  cmd;
  ist_pkg::stat_t stat;

  ist_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ist_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_value          (in_value),
    .in_random_word    (in_random_word),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_is_member     (out_is_member),
    .out_sample_value  (out_sample_value),
    .out_element_count (out_element_count),
    .out_set_empty     (out_set_empty)
  );

endmodule

// File: src/ist_datapath.sv
// element store, search, shift, modulo and result registers of the set table
module ist_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ist_pkg::cmd_t               cmd,
  output ist_pkg::stat_t              stat,
  input  logic [1:0]                  in_func,
  input  logic [ist_pkg::VAL_W-1:0]   in_value,
  input  logic [ist_pkg::RND_W-1:0]   in_random_word,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic                        out_is_member,
  output logic [ist_pkg::VAL_W-1:0]   out_sample_value,
  output logic [ist_pkg::CNT_W-1:0]   out_element_count,
  output logic                        out_set_empty
);

  logic [ist_pkg::VAL_W-1:0]     store_r [ist_pkg::CAPACITY];
  logic [ist_pkg::VAL_W-1:0]     rd_data_r;
  logic [ist_pkg::ADDR_W-1:0]    rd_addr;
  logic                          wr_en;
  logic [ist_pkg::ADDR_W-1:0]    wr_addr;
  logic [ist_pkg::VAL_W-1:0]     wr_data;

  ist_pkg::func_t                func_r;
  logic [ist_pkg::VAL_W-1:0]     value_r;
  logic [ist_pkg::RND_W-1:0]     rnd_r;
  logic [ist_pkg::CNT_W-1:0]     count_r;
  logic [ist_pkg::CNT_W-1:0]     count_nxt;
  logic [ist_pkg::CNT_W-1:0]     idx_r;
  logic                          cmp_vld_r;
  logic [ist_pkg::ADDR_W-1:0]    cmp_addr_r;
  logic                          found_r;
  logic [ist_pkg::ADDR_W-1:0]    pos_r;
  logic                          mv_vld_r;
  logic [ist_pkg::ADDR_W-1:0]    mv_addr_r;
  logic [ist_pkg::CNT_W-1:0]     rem_r;
  logic [ist_pkg::CNT_W:0]       rem_sh;
  logic [ist_pkg::CNT_W-1:0]     rem_nxt;
  logic [ist_pkg::MOD_CNT_W-1:0] mod_cnt_r;

  logic                          out_valid_r;
  ist_pkg::status_t              out_status_r;
  logic                          out_member_r;
  logic [ist_pkg::VAL_W-1:0]     out_sample_r;
  logic [ist_pkg::CNT_W-1:0]     out_count_r;
  logic                          out_empty_r;

  // read port address
  always_comb begin
    if (cmd.shift_up) begin
      rd_addr = ist_pkg::ADDR_W'(idx_r - ist_pkg::CNT_W'(1));
    end else if (cmd.sample_rd) begin
      rd_addr = rem_r[ist_pkg::ADDR_W-1:0];
    end else begin
      rd_addr = idx_r[ist_pkg::ADDR_W-1:0];
    end
  end

  // one write port: shifted entry or new head
  always_comb begin
    wr_en   = mv_vld_r | cmd.wr_head;
    wr_addr = mv_vld_r ? mv_addr_r : '0;
    wr_data = mv_vld_r ? rd_data_r : value_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    rd_data_r <= store_r[rd_addr];
  end

  // restoring remainder, one bit of the random word per cycle
  always_comb begin
    rem_sh = {rem_r, rnd_r[ist_pkg::RND_W-1]};
    if (rem_sh >= {1'b0, count_r}) begin
      rem_nxt = ist_pkg::CNT_W'(rem_sh - {1'b0, count_r});
    end else begin
      rem_nxt = rem_sh[ist_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + ist_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - ist_pkg::CNT_W'(1);
    end
  end

  // request word and remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= ist_pkg::func_t'(in_func);
      value_r <= in_value;
      rnd_r   <= in_random_word;
      rem_r   <= '0;
    end else if (mod_cnt_r != '0) begin
      rnd_r <= rnd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  // control side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      mv_vld_r    <= 1'b0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
      cmp_vld_r   <= cmd.scan && (idx_r < count_r);
      mv_vld_r    <= (cmd.shift_up && (idx_r != '0)) || (cmd.shift_dn && (idx_r < count_r));
      if (cmd.load) begin
        mod_cnt_r <= ist_pkg::MOD_CNT_W'(ist_pkg::RND_W);
      end else if (mod_cnt_r != '0) begin
        mod_cnt_r <= mod_cnt_r - ist_pkg::MOD_CNT_W'(1);
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.scan && (idx_r < count_r)) begin
        idx_r <= idx_r + ist_pkg::CNT_W'(1);
      end else if (cmd.dn_init) begin
        idx_r <= ist_pkg::CNT_W'(pos_r) + ist_pkg::CNT_W'(1);
      end else if (cmd.shift_up && (idx_r != '0)) begin
        idx_r <= idx_r - ist_pkg::CNT_W'(1);
      end else if (cmd.shift_dn && (idx_r < count_r)) begin
        idx_r <= idx_r + ist_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmp_vld_r && (rd_data_r == value_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  // payload side of search and shift
  always_ff @(posedge clk) begin
    cmp_addr_r <= idx_r[ist_pkg::ADDR_W-1:0];
    if (cmp_vld_r && (rd_data_r == value_r)) begin
      pos_r <= cmp_addr_r;
    end
    if (cmd.shift_up) begin
      mv_addr_r <= idx_r[ist_pkg::ADDR_W-1:0];
    end else begin
      mv_addr_r <= ist_pkg::ADDR_W'(idx_r - ist_pkg::CNT_W'(1));
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.code;
      out_member_r <= found_r;
      out_sample_r <= cmd.take_sample ? rd_data_r : '0;
      out_count_r  <= count_nxt;
      out_empty_r  <= (count_nxt == '0);
    end
  end

  always_comb begin
    stat.scan_done  = (idx_r == count_r) && !cmp_vld_r;
    stat.mod_done   = (mod_cnt_r == '0);
    stat.shift_done = !mv_vld_r &&
                      ((func_r == ist_pkg::FUNC_INSERT) ? (idx_r == '0) : (idx_r >= count_r));
    stat.found      = found_r;
    stat.full       = (count_r == ist_pkg::CNT_W'(ist_pkg::CAPACITY));
    stat.empty      = (count_r == '0);
    stat.func       = func_r;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_member     = out_member_r;
  assign out_sample_value  = out_sample_r;
  assign out_element_count = out_count_r;
  assign out_set_empty     = out_empty_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mv_vld_r |-> !cmd.wr_head)
    else $error("shift write collides with head write");

  a_remove_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dn_init |-> (found_r && (ist_pkg::CNT_W'(pos_r) < count_r)))
    else $error("remove started without a valid match position");

  a_sample_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sample_rd |-> ((mod_cnt_r == '0) && (count_r != '0) && (rem_r < count_r)))
    else $error("sample read before remainder ready or out of range");

endmodule

// File: src/ist_controller.sv
// request sequencer of the set table
module ist_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ist_pkg::stat_t stat,
  output ist_pkg::cmd_t  cmd
);

  ist_pkg::state_t state_r;
  ist_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ist_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ist_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = ist_pkg::S_SCAN;
        end
      end
      ist_pkg::S_SCAN: begin
        if (stat.scan_done && stat.mod_done) begin
          case (stat.func)
            ist_pkg::FUNC_INSERT: begin
              if (stat.found) begin
                state_nxt = ist_pkg::S_FIN_DUP;
              end else if (stat.full) begin
                state_nxt = ist_pkg::S_FIN_FULL;
              end else begin
                state_nxt = ist_pkg::S_SHIFT_UP;
              end
            end
            ist_pkg::FUNC_REMOVE: begin
              state_nxt = stat.found ? ist_pkg::S_PREP_DN : ist_pkg::S_FIN_ABSENT;
            end
            ist_pkg::FUNC_QUERY: begin
              state_nxt = ist_pkg::S_FIN_OK;
            end
            default: begin
              state_nxt = stat.empty ? ist_pkg::S_FIN_EMPTY : ist_pkg::S_SAMPLE_RD;
            end
          endcase
        end
      end
      ist_pkg::S_PREP_DN:   state_nxt = ist_pkg::S_SHIFT_DN;
      ist_pkg::S_SHIFT_UP: begin
        if (stat.shift_done) begin
          state_nxt = ist_pkg::S_FIN_INS;
        end
      end
      ist_pkg::S_SHIFT_DN: begin
        if (stat.shift_done) begin
          state_nxt = ist_pkg::S_FIN_REM;
        end
      end
      ist_pkg::S_SAMPLE_RD: state_nxt = ist_pkg::S_FIN_SAMPLE;
      default:              state_nxt = ist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = ist_pkg::ST_OK;
    case (state_r)
      ist_pkg::S_IDLE:       cmd.load      = start;
      ist_pkg::S_SCAN:       cmd.scan      = 1'b1;
      ist_pkg::S_PREP_DN:    cmd.dn_init   = 1'b1;
      ist_pkg::S_SHIFT_UP:   cmd.shift_up  = 1'b1;
      ist_pkg::S_SHIFT_DN:   cmd.shift_dn  = 1'b1;
      ist_pkg::S_SAMPLE_RD:  cmd.sample_rd = 1'b1;
      ist_pkg::S_FIN_OK:     cmd.finish    = 1'b1;
      ist_pkg::S_FIN_DUP: begin
        cmd.finish = 1'b1;
        cmd.code   = ist_pkg::ST_DUPLICATE;
      end
      ist_pkg::S_FIN_FULL: begin
        cmd.finish = 1'b1;
        cmd.code   = ist_pkg::ST_FULL;
      end
      ist_pkg::S_FIN_ABSENT: begin
        cmd.finish = 1'b1;
        cmd.code   = ist_pkg::ST_NOT_FOUND;
      end
      ist_pkg::S_FIN_EMPTY: begin
        cmd.finish = 1'b1;
        cmd.code   = ist_pkg::ST_EMPTY;
      end
      ist_pkg::S_FIN_INS: begin
        cmd.finish  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.wr_head = 1'b1;
      end
      ist_pkg::S_FIN_REM: begin
        cmd.finish  = 1'b1;
        cmd.cnt_dec = 1'b1;
      end
      ist_pkg::S_FIN_SAMPLE: begin
        cmd.finish      = 1'b1;
        cmd.take_sample = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != ist_pkg::S_IDLE);

endmodule
